@@ sv/assert_macros.svh @@
// Assertion helpers used by the matcher core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ALCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ALCM_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/alcm_pkg.sv @@
package alcm_pkg;

  localparam int unsigned LitBytes = 8;
  localparam int unsigned LitW     = 8 * LitBytes;
  localparam int unsigned PosW     = 16;
  localparam int unsigned LenW     = 4;

  localparam logic [7:0] CharUnderscore = 8'h5F;

  typedef enum logic [2:0] {
    MODE_CONTAINS = 3'd0,
    MODE_STARTS   = 3'd1,
    MODE_ENDS     = 3'd2,
    MODE_EXACT    = 3'd3,
    MODE_SHAPE    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CLASS_DIGIT = 2'd0,
    CLASS_WORD  = 2'd1,
    CLASS_SPACE = 2'd2,
    CLASS_ANY   = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    CFG_MATCH_MODE    = 3'd0,
    CFG_LITERAL_BYTES = 3'd1,
    CFG_LITERAL_LEN   = 3'd2,
    CFG_CHAR_CLASS    = 3'd3,
    CFG_MIN_REPEAT    = 3'd4,
    CFG_MAX_REPEAT    = 3'd5,
    CFG_MAX_UNBOUNDED = 3'd6,
    CFG_ALSO_LITERAL  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]      match_mode;
    logic [LitW-1:0] literal_bytes;
    logic [3:0]      literal_len;
    logic [1:0]      char_class;
    logic [15:0]     min_repeat;
    logic [15:0]     max_repeat;
    logic            max_unbounded;
    logic            also_try_literal;
  } cfg_t;

  // Per-text running state as seen after the current byte.
  typedef struct packed {
    logic [PosW-1:0] position;
    logic            prefix_ok;
    logic            hit_found;
    logic [PosW-1:0] hit_start;
    logic            class_ok;
    logic            tail_ok;
    logic [LenW-1:0] lit_n;
  } track_t;

  // Literal length clipped to the window size.
  function automatic logic [LenW-1:0] lit_count(input logic [3:0] len);
    logic [LenW-1:0] n;
    n = (len > 4'(LitBytes)) ? LenW'(LitBytes) : LenW'(len);
    return n;
  endfunction

endpackage

@@ sv/alcm_track.sv @@
module alcm_track (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  alcm_pkg::cfg_t       cfg_i,
  input  logic                 take_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 is_last_i,
  input  logic                 no_byte_i,
  output alcm_pkg::track_t     state_o
);

  localparam int unsigned PosW = alcm_pkg::PosW;
  localparam int unsigned LitW = alcm_pkg::LitW;
  localparam int unsigned LitB = alcm_pkg::LitBytes;

  logic [PosW-1:0] pos_q, pos_d, pos_n;
  logic [LitW-1:0] win_q, win_d, win_n;
  logic            prefix_q, prefix_d, prefix_n;
  logic            hit_q, hit_d, hit_n;
  logic [PosW-1:0] hit_start_q, hit_start_d, hit_start_n;
  logic            class_q, class_d, class_n;
  logic [alcm_pkg::LenW-1:0] lit_n;
  logic [LitB:0]   tail_eq;
  logic            tail_ok;

  function automatic logic in_class(input logic [1:0] cls, input logic [7:0] c);
    logic r;
    case (cls)
      alcm_pkg::CLASS_DIGIT: r = c inside {["0":"9"]};
      alcm_pkg::CLASS_WORD:  r = c inside {["0":"9"], ["a":"z"], ["A":"Z"],
                                           alcm_pkg::CharUnderscore};
      alcm_pkg::CLASS_SPACE: r = c inside {8'h20, [8'h09:8'h0D]};
      default:               r = 1'b1;
    endcase
    return r;
  endfunction

  assign lit_n = alcm_pkg::lit_count(cfg_i.literal_len);

  // Window and counters after taking the current byte.
  always_comb begin
    pos_n    = (pos_q == {PosW{1'b1}}) ? pos_q : pos_q + PosW'(1);
    win_n    = {text_byte_i, win_q[LitW-1:8]};
    prefix_n = prefix_q;
    if ((pos_q < PosW'(lit_n)) &&
        (cfg_i.literal_bytes[8*pos_q[2:0] +: 8] != text_byte_i)) begin
      prefix_n = 1'b0;
    end
    class_n = class_q & in_class(cfg_i.char_class, text_byte_i);
  end

  assign win_d = no_byte_i ? win_q : win_n;

  // Tail of the window against the literal, one compare per length.
  assign tail_eq[0] = 1'b1;
  for (genvar k = 1; k <= LitB; k++) begin : g_tail
    assign tail_eq[k] = (win_d[LitW-1 -: 8*k] == cfg_i.literal_bytes[8*k-1:0]);
  end
  assign tail_ok = tail_eq[lit_n];

  always_comb begin
    hit_n       = hit_q;
    hit_start_n = hit_start_q;
    if (!hit_q && (lit_n != '0) && (pos_n >= PosW'(lit_n)) && tail_ok) begin
      hit_n       = 1'b1;
      hit_start_n = pos_n - PosW'(lit_n);
    end
  end

  assign pos_d       = no_byte_i ? pos_q       : pos_n;
  assign prefix_d    = no_byte_i ? prefix_q    : prefix_n;
  assign class_d     = no_byte_i ? class_q     : class_n;
  assign hit_d       = no_byte_i ? hit_q       : hit_n;
  assign hit_start_d = no_byte_i ? hit_start_q : hit_start_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      win_q       <= '0;
      prefix_q    <= 1'b1;
      hit_q       <= 1'b0;
      hit_start_q <= '0;
      class_q     <= 1'b1;
    end else if (take_i) begin
      if (is_last_i) begin
        pos_q       <= '0;
        win_q       <= '0;
        prefix_q    <= 1'b1;
        hit_q       <= 1'b0;
        hit_start_q <= '0;
        class_q     <= 1'b1;
      end else begin
        pos_q       <= pos_d;
        win_q       <= win_d;
        prefix_q    <= prefix_d;
        hit_q       <= hit_d;
        hit_start_q <= hit_start_d;
        class_q     <= class_d;
      end
    end
  end

  always_comb begin
    state_o.position  = pos_d;
    state_o.prefix_ok = prefix_d;
    state_o.hit_found = hit_d;
    state_o.hit_start = hit_start_d;
    state_o.class_ok  = class_d;
    state_o.tail_ok   = tail_ok;
    state_o.lit_n     = lit_n;
  end

endmodule

@@ sv/alcm_judge.sv @@
module alcm_judge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alcm_pkg::cfg_t   cfg_i,
  input  alcm_pkg::track_t state_i,
  input  logic             load_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic             matched_o,
  output logic [15:0]      match_start_o,
  output logic [15:0]      match_end_o,
  output logic [15:0]      match_length_o
);

  localparam int unsigned PosW = alcm_pkg::PosW;

  logic            m;
  logic [PosW-1:0] start, len, n16;
  logic            shape_ok;
  logic            valid_q, valid_d;
  logic            matched_q;
  logic [15:0]     start_q, end_q, len_q;

  assign n16 = PosW'(state_i.lit_n);
  assign shape_ok = state_i.class_ok && (state_i.position >= cfg_i.min_repeat) &&
                    (cfg_i.max_unbounded || (state_i.position <= cfg_i.max_repeat));

  always_comb begin
    m     = 1'b0;
    start = '0;
    len   = '0;
    case (cfg_i.match_mode)
      alcm_pkg::MODE_CONTAINS: begin
        if (n16 == '0) begin
          m = 1'b1;
        end else if (state_i.hit_found) begin
          m     = 1'b1;
          start = state_i.hit_start;
          len   = n16;
        end
      end
      alcm_pkg::MODE_STARTS: begin
        if (state_i.prefix_ok && (state_i.position >= n16)) begin
          m   = 1'b1;
          len = n16;
        end
      end
      alcm_pkg::MODE_ENDS: begin
        if ((state_i.position >= n16) && state_i.tail_ok) begin
          m     = 1'b1;
          start = state_i.position - n16;
          len   = n16;
        end
      end
      alcm_pkg::MODE_EXACT: begin
        if (state_i.prefix_ok && (state_i.position == n16)) begin
          m   = 1'b1;
          len = n16;
        end
      end
      alcm_pkg::MODE_SHAPE: begin
        if (shape_ok) begin
          m   = 1'b1;
          len = state_i.position;
        end else if (cfg_i.also_try_literal && state_i.prefix_ok &&
                     (state_i.position == n16)) begin
          m   = 1'b1;
          len = n16;
        end
      end
      default: begin
        m = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      matched_q <= m;
      start_q   <= start[15:0];
      end_q     <= 16'(start + len);
      len_q     <= len[15:0];
    end
  end

  assign out_valid_o    = valid_q;
  assign matched_o      = matched_q;
  assign match_start_o  = start_q;
  assign match_end_o    = end_q;
  assign match_length_o = len_q;

endmodule

@@ sv/anchored_literal_and_class_matcher_core.sv @@
// Anchored literal and character-class matcher.
// Input channel: one text byte per transaction (in_valid_i / in_stall_o) with
// is_last_i closing a text and no_byte_i marking a transaction without a
// character (used to close an empty text, or as an idle filler).
// Output channel: one result per closed text (out_valid_o / out_stall_i):
// matched flag, start, end and length of the match; all zero on a miss.
// Configuration: cfg_we_i writes register cfg_index_i with cfg_wdata_i; the user
// must write only while no text is in flight (the block does not enforce this).
// Result path: a closing transaction lands in the input register when it is
// accepted and moves into the result register once the result slot is free,
// which raises out_valid_o.
// Throughput: one transaction per cycle while in_stall_o is low; the per-byte window compare and
// flag update is a single shallow stage, and the result register lets the
// next text stream in while a result waits.
// Stall: while out_stall_i holds a result, byte transactions keep flowing;
// only a closing transaction waits in the input register, which then raises
// in_stall_o until the result is taken.
// Reset: clears valid flags, configuration and tracking state and empties both stages.
`include "assert_macros.svh"

module anchored_literal_and_class_matcher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        is_last_i,
  input  logic        no_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        matched_o,
  output logic [15:0] match_start_o,
  output logic [15:0] match_end_o,
  output logic [15:0] match_length_o
);

  alcm_pkg::cfg_t   cfg_q;
  alcm_pkg::track_t track;

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       nobyte_q;
  logic       out_free;
  logic       advance;
  logic       in_take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_mode       <= alcm_pkg::MODE_CONTAINS;
      cfg_q.literal_bytes    <= '0;
      cfg_q.literal_len      <= '0;
      cfg_q.char_class       <= alcm_pkg::CLASS_DIGIT;
      cfg_q.min_repeat       <= 16'd1;
      cfg_q.max_repeat       <= 16'd1;
      cfg_q.max_unbounded    <= 1'b0;
      cfg_q.also_try_literal <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        alcm_pkg::CFG_MATCH_MODE:    cfg_q.match_mode       <= cfg_wdata_i[2:0];
        alcm_pkg::CFG_LITERAL_BYTES: cfg_q.literal_bytes    <= cfg_wdata_i;
        alcm_pkg::CFG_LITERAL_LEN:   cfg_q.literal_len      <= cfg_wdata_i[3:0];
        alcm_pkg::CFG_CHAR_CLASS:    cfg_q.char_class       <= cfg_wdata_i[1:0];
        alcm_pkg::CFG_MIN_REPEAT:    cfg_q.min_repeat       <= cfg_wdata_i[15:0];
        alcm_pkg::CFG_MAX_REPEAT:    cfg_q.max_repeat       <= cfg_wdata_i[15:0];
        alcm_pkg::CFG_MAX_UNBOUNDED: cfg_q.max_unbounded    <= cfg_wdata_i[0];
        alcm_pkg::CFG_ALSO_LITERAL:  cfg_q.also_try_literal <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // The result slot frees up this cycle if empty or being taken.
  assign out_free = !out_valid_o || !out_stall_i;
  // Advance the staged transaction: bytes always, a closing one only into a free slot.
  assign advance  = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Hold the staged payload until it advances.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q   <= text_byte_i;
      last_q   <= is_last_i;
      nobyte_q <= no_byte_i;
    end
  end

  alcm_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .take_i      (advance),
    .text_byte_i (byte_q),
    .is_last_i   (last_q),
    .no_byte_i   (nobyte_q),
    .state_o     (track)
  );

  alcm_judge u_judge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .state_i        (track),
    .load_i         (advance && last_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .matched_o      (matched_o),
    .match_start_o  (match_start_o),
    .match_end_o    (match_end_o),
    .match_length_o (match_length_o)
  );

  `ALCM_ASSERT(a_close_gives_result, (advance && last_q) |=> out_valid_o,
    "closing transaction lost")
  `ALCM_ASSERT(a_miss_is_zero, (out_valid_o && !matched_o) |->
    ((match_start_o == 16'd0) && (match_end_o == 16'd0) && (match_length_o == 16'd0)),
    "miss carries offsets")
  `ALCM_ASSERT(a_end_consistent,
    out_valid_o |-> (match_end_o == 16'(match_start_o + match_length_o)),
    "match end inconsistent")
  `ALCM_ASSERT_NR(a_stall_needs_item,
    in_stall_o |-> (in_valid_q && last_q && out_valid_o),
    "stall without a waiting close")

endmodule
